FILE: rtl/core/rhnp_pkg.sv
package rhnp_pkg;

  localparam logic [20:0] MaxNalBytes   = 21'd1048576;
  localparam logic [20:0] MinNalBytes   = 21'd5;
  localparam logic [20:0] PrefixBytes   = 21'd4;
  localparam logic [10:0] MinPayload    = 11'd2;

  localparam logic [7:0]  RtpVersionByte = 8'h80;
  localparam logic [4:0]  FuaType        = 5'd28;

  localparam logic [1:0]  RegPayloadType  = 2'd0;
  localparam logic [1:0]  RegSourceId     = 2'd1;
  localparam logic [1:0]  RegMaxPayload   = 2'd2;
  localparam logic [1:0]  RegTimestampStep = 2'd3;

  localparam logic [3:0]  ByteVersion   = 4'd0;
  localparam logic [3:0]  BytePtMarker  = 4'd1;
  localparam logic [3:0]  ByteSeqHi     = 4'd2;
  localparam logic [3:0]  ByteSeqLo     = 4'd3;
  localparam logic [3:0]  ByteTs3       = 4'd4;
  localparam logic [3:0]  ByteTs2       = 4'd5;
  localparam logic [3:0]  ByteTs1       = 4'd6;
  localparam logic [3:0]  ByteTs0       = 4'd7;
  localparam logic [3:0]  ByteSsrc3     = 4'd8;
  localparam logic [3:0]  ByteSsrc2     = 4'd9;
  localparam logic [3:0]  ByteSsrc1     = 4'd10;
  localparam logic [3:0]  ByteSsrc0     = 4'd11;
  localparam logic [3:0]  ByteFuInd     = 4'd12;
  localparam logic [3:0]  ByteFuHdr     = 4'd13;
  localparam logic [3:0]  BytePayload   = 4'd14;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic        has_hdr;
    logic        fu;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        data_last;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  payload_type;
    logic [31:0] source_id;
  } hdr_cfg_t;

endpackage

FILE: rtl/core/rhnp_front.sv
module rhnp_front
  import rhnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [20:0] nal_length,
  input  logic [10:0] max_payload,
  input  logic [16:0] timestamp_step,
  output logic        push,
  output cmd_t        cmd
);

  logic [15:0] seq_r, seq_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic [20:0] pos_r, pos_nxt;
  logic [20:0] len_r, len_nxt;
  logic [10:0] fill_r, fill_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic        frag_r, frag_nxt;
  logic        drop_r, drop_nxt;

  logic [20:0] pos_c;
  logic [20:0] start_c;
  logic [10:0] fill_c;
  logic        last_c;
  logic        lf_c;
  logic        emit;

  always_comb begin
    pos_c    = pos_r;
    len_nxt  = len_r;
    fill_nxt = fill_r;
    hdr_nxt  = hdr_r;
    frag_nxt = frag_r;
    drop_nxt = drop_r;
    ts_nxt   = ts_r;
    seq_nxt  = seq_r;
    start_c  = pos_r;
    fill_c   = fill_r;
    lf_c     = 1'b0;
    emit     = 1'b0;
    cmd      = '0;
    if (first_byte) begin
      pos_c    = '0;
      fill_nxt = '0;
      hdr_nxt  = '0;
      if (nal_length <= MinNalBytes || nal_length > MaxNalBytes) begin
        drop_nxt = 1'b1;
        len_nxt  = '0;
        frag_nxt = 1'b0;
      end else begin
        drop_nxt = 1'b0;
        len_nxt  = nal_length;
        ts_nxt   = ts_r + {15'd0, timestamp_step};
        frag_nxt = (nal_length - PrefixBytes) > {10'd0, max_payload};
      end
    end
    pos_nxt = pos_c;
    last_c  = (pos_c == len_nxt - 21'd1);
    cmd.data      = data_byte;
    cmd.ts        = ts_nxt;
    if (!drop_nxt && pos_c < len_nxt) begin
      pos_nxt = pos_c + 21'd1;
      if (pos_c >= PrefixBytes) begin
        if (pos_c == PrefixBytes) begin
          // nal header byte
          hdr_nxt = data_byte;
          if (!frag_nxt) begin
            seq_nxt     = seq_r + 16'd1;
            emit        = 1'b1;
            cmd.has_hdr = 1'b1;
          end
        end else if (!frag_nxt) begin
          emit          = 1'b1;
          cmd.data_last = last_c;
        end else begin
          emit = 1'b1;
          if (fill_r == '0) begin
            start_c     = (pos_c == PrefixBytes + 21'd1) ? PrefixBytes : pos_c;
            lf_c        = ({1'b0, start_c} + {11'd0, max_payload}) >= {1'b0, len_nxt};
            seq_nxt     = seq_r + 16'd1;
            cmd.has_hdr = 1'b1;
            cmd.fu      = 1'b1;
            cmd.marker  = lf_c;
            cmd.fu_ind  = {hdr_r[7:5], FuaType};
            cmd.fu_hdr  = {(pos_c == PrefixBytes + 21'd1), lf_c, 1'b0, hdr_r[4:0]};
            fill_c      = (pos_c == PrefixBytes + 21'd1) ? 11'd1 : 11'd0;
          end
          fill_c = fill_c + 11'd1;
          if (fill_c >= max_payload || last_c) begin
            fill_nxt      = '0;
            cmd.data_last = 1'b1;
          end else begin
            fill_nxt = fill_c;
          end
        end
      end
    end
    cmd.seq = seq_nxt;
  end

  assign push = take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= '0;
      ts_r   <= '0;
      pos_r  <= '0;
      len_r  <= '0;
      fill_r <= '0;
      hdr_r  <= '0;
      frag_r <= 1'b0;
      drop_r <= 1'b0;
    end else if (take) begin
      seq_r  <= seq_nxt;
      ts_r   <= ts_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      fill_r <= fill_nxt;
      hdr_r  <= hdr_nxt;
      frag_r <= frag_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

FILE: rtl/core/rhnp_queue.sv
module rhnp_queue
  import rhnp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head_cmd
);

  cmd_t                 mem_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_r, rd_r;
  logic [QueuePtrW:0]   cnt_r;

  assign full      = (cnt_r == (QueuePtrW+1)'(QueueDepth));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/core/rhnp_back.sv
module rhnp_back
  import rhnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  input  hdr_cfg_t   hdr_cfg,
  output logic       pop,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       out_ready
);

  logic [3:0] cnt_r;
  logic [3:0] sel;
  logic [7:0] byte_c;
  logic       advance;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  always_comb begin
    if (!cmd.has_hdr || (!cmd.fu && cnt_r == ByteFuInd)) begin
      sel = BytePayload;
    end else begin
      sel = cnt_r;
    end
  end

  always_comb begin
    case (sel)
      ByteVersion:  byte_c = RtpVersionByte;
      BytePtMarker: byte_c = {cmd.marker, hdr_cfg.payload_type};
      ByteSeqHi:    byte_c = cmd.seq[15:8];
      ByteSeqLo:    byte_c = cmd.seq[7:0];
      ByteTs3:      byte_c = cmd.ts[31:24];
      ByteTs2:      byte_c = cmd.ts[23:16];
      ByteTs1:      byte_c = cmd.ts[15:8];
      ByteTs0:      byte_c = cmd.ts[7:0];
      ByteSsrc3:    byte_c = hdr_cfg.source_id[31:24];
      ByteSsrc2:    byte_c = hdr_cfg.source_id[23:16];
      ByteSsrc1:    byte_c = hdr_cfg.source_id[15:8];
      ByteSsrc0:    byte_c = hdr_cfg.source_id[7:0];
      ByteFuInd:    byte_c = cmd.fu_ind;
      ByteFuHdr:    byte_c = cmd.fu_hdr;
      default:      byte_c = cmd.data;
    endcase
  end

  assign advance = !valid_r || out_ready;
  assign pop     = cmd_valid && advance && (sel == BytePayload);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= cmd_valid;
      if (cmd_valid) begin
        cnt_r <= (sel == BytePayload) ? 4'd0 : cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cmd_valid) begin
      byte_r <= byte_c;
      last_r <= (sel == BytePayload) && cmd.data_last;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

FILE: rtl/core/rtp_h264_nal_packetizer.sv
// channel   dir   handshake                transaction
// in_       in    in_tvalid / in_tready    one nal unit byte, prefix included
// out_      out   out_tvalid / out_tready  one rtp packet byte, tlast on final byte
// cfg_      in    apb psel / penable       register write or read, pready tied high
//
// one input byte per cycle while the command queue has room; the byte serialiser
// sends the rtp header before each packet, plus the fu indicator and fu header for
// a fu-a fragment start, so the queue fills and the input stalls during those bursts
// output is registered; synchronous active-low reset clears all control state
module rtp_h264_nal_packetizer
  import rhnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // data_byte [7:0], nal_length [28:8], zero [31:29]
  input  logic        in_tuser,    // first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // out_byte [7:0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [6:0]  payload_type_r;
  logic [31:0] source_id_r;
  logic [10:0] max_payload_r;
  logic [16:0] timestamp_step_r;
  logic [10:0] eff_payload;
  logic        wr_en;

  logic        take;
  logic        q_push;
  cmd_t        q_in;
  logic        q_full;
  logic        q_valid;
  cmd_t        q_head;
  logic        q_pop;
  hdr_cfg_t    hdr_cfg;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_type_r   <= 7'd96;
      source_id_r      <= '0;
      max_payload_r    <= 11'd1000;
      timestamp_step_r <= 17'd3000;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        RegPayloadType:   payload_type_r   <= cfg_pwdata[6:0];
        RegSourceId:      source_id_r      <= cfg_pwdata;
        RegMaxPayload:    max_payload_r    <= cfg_pwdata[10:0];
        RegTimestampStep: timestamp_step_r <= cfg_pwdata[16:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      RegPayloadType:   cfg_prdata = {25'd0, payload_type_r};
      RegSourceId:      cfg_prdata = source_id_r;
      RegMaxPayload:    cfg_prdata = {21'd0, max_payload_r};
      RegTimestampStep: cfg_prdata = {15'd0, timestamp_step_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign eff_payload = (max_payload_r < MinPayload) ? MinPayload : max_payload_r;
  assign hdr_cfg     = '{payload_type: payload_type_r, source_id: source_id_r};

  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;

  rhnp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .data_byte      (in_tdata[7:0]),
    .first_byte     (in_tuser),
    .nal_length     (in_tdata[28:8]),
    .max_payload    (eff_payload),
    .timestamp_step (timestamp_step_r),
    .push           (q_push),
    .cmd            (q_in)
  );

  rhnp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_cmd  (q_head)
  );

  rhnp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .hdr_cfg   (hdr_cfg),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

endmodule

FILE: test/tb_rtp_h264_nal_packetizer.sv
module tb_rtp_h264_nal_packetizer
  import rhnp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned HoldAfterBytes = 190;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [20:0] nal_length;
  } nal_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_last;
  } rtp_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // data_byte [7:0], nal_length [28:8], zero [31:29]
  logic        in_tuser = 1'b0;  // first_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // out_byte [7:0]
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rtp_h264_nal_packetizer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nal_item_t   nal_bytes_to_send[$];
  rtp_byte_t   rtp_bytes_due[$];
  int unsigned mismatches = 0;
  int unsigned rtp_bytes_seen = 0;
  int unsigned cycle_count = 0;

  // packetizer image: registers and state
  logic [6:0]  pt_reg;
  logic [31:0] ssrc_reg;
  logic [10:0] max_payload_reg;
  logic [16:0] ts_step_reg;
  logic [15:0] seq_no;
  logic [31:0] ts_now;
  logic [20:0] unit_pos;
  logic [20:0] unit_len;
  int unsigned frag_fill;
  logic [7:0]  nal_hdr;
  logic        frag_mode;
  logic        drop_unit;

  function automatic void reset_packetizer_image();
    pt_reg = 7'd96;
    ssrc_reg = '0;
    max_payload_reg = 11'd1000;
    ts_step_reg = 17'd3000;
    seq_no = '0;
    ts_now = '0;
    unit_pos = '0;
    unit_len = '0;
    frag_fill = 0;
    nal_hdr = '0;
    frag_mode = 1'b0;
    drop_unit = 1'b0;
  endfunction

  function automatic void expect_byte(input logic [7:0] b, input logic last_flag);
    rtp_byte_t e;
    e.out_byte = b;
    e.packet_last = last_flag;
    rtp_bytes_due.push_back(e);
  endfunction

  function automatic void expect_rtp_header(input logic marker);
    seq_no = seq_no + 16'd1;
    expect_byte(RtpVersionByte, 1'b0);
    expect_byte({marker, pt_reg}, 1'b0);
    expect_byte(seq_no[15:8], 1'b0);
    expect_byte(seq_no[7:0], 1'b0);
    expect_byte(ts_now[31:24], 1'b0);
    expect_byte(ts_now[23:16], 1'b0);
    expect_byte(ts_now[15:8], 1'b0);
    expect_byte(ts_now[7:0], 1'b0);
    expect_byte(ssrc_reg[31:24], 1'b0);
    expect_byte(ssrc_reg[23:16], 1'b0);
    expect_byte(ssrc_reg[15:8], 1'b0);
    expect_byte(ssrc_reg[7:0], 1'b0);
  endfunction

  // works out the packet bytes that one accepted nal byte causes
  function automatic void packetize_byte(input nal_item_t it);
    int unsigned mp;
    int unsigned p;
    int unsigned nal_len;
    int unsigned start;
    logic        last_frag;
    mp = (max_payload_reg < MinPayload) ? int'(MinPayload) : int'(max_payload_reg);
    if (it.first_byte) begin
      unit_pos = '0;
      frag_fill = 0;
      nal_hdr = '0;
      if (it.nal_length <= MinNalBytes || it.nal_length > MaxNalBytes) begin
        drop_unit = 1'b1;
        unit_len = '0;
        frag_mode = 1'b0;
        return;
      end
      drop_unit = 1'b0;
      unit_len = it.nal_length;
      ts_now = ts_now + ts_step_reg;
      frag_mode = (int'(it.nal_length) - int'(PrefixBytes)) > mp;
    end
    if (drop_unit || unit_pos >= unit_len) return;
    p = unit_pos;
    unit_pos = unit_pos + 21'd1;
    if (p < PrefixBytes) return;
    p = p - PrefixBytes;
    nal_len = unit_len - PrefixBytes;
    if (p == 0) begin
      nal_hdr = it.data_byte;
      if (!frag_mode) begin
        expect_rtp_header(1'b0);
        expect_byte(it.data_byte, 1'b0);
      end
      return;
    end
    if (!frag_mode) begin
      expect_byte(it.data_byte, p == nal_len - 1);
      return;
    end
    if (frag_fill == 0) begin
      start = (p == 1) ? 0 : p;
      last_frag = (start + mp >= nal_len);
      expect_rtp_header(last_frag);
      expect_byte({nal_hdr[7:5], FuaType}, 1'b0);
      expect_byte({p == 1, last_frag, 1'b0, nal_hdr[4:0]}, 1'b0);
      frag_fill = (p == 1) ? 1 : 0;
    end
    frag_fill++;
    if (frag_fill >= mp || p == nal_len - 1) begin
      frag_fill = 0;
      expect_byte(it.data_byte, 1'b1);
    end else begin
      expect_byte(it.data_byte, 1'b0);
    end
  endfunction

  // per-transaction wait, with calm stretches of no idling
  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // sender
  nal_item_t   cur_item;
  int unsigned in_gap;
  bit          in_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
      in_calm = 1'b0;
    end else begin
      if (in_tvalid && in_tready) packetize_byte(cur_item);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (nal_bytes_to_send.size() > 0) begin
          cur_item = nal_bytes_to_send.pop_front();
          in_tdata <= {3'b000, cur_item.nal_length, cur_item.data_byte};
          in_tuser <= cur_item.first_byte;
          in_tvalid <= 1'b1;
          in_gap = draw_gap(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once
  int unsigned hold_left;
  bit          hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && rtp_bytes_seen >= HoldAfterBytes) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  int unsigned out_gap;
  bit          out_calm;
  rtp_byte_t   want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
      out_calm = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        rtp_bytes_seen <= rtp_bytes_seen + 1;
        if (rtp_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected rtp byte %02h last %0b", out_tdata, out_tlast);
        end else begin
          want = rtp_bytes_due.pop_front();
          if (want.out_byte !== out_tdata || want.packet_last !== out_tlast) begin
            mismatches++;
            if (mismatches <= 10)
              $display("rtp byte mismatch: expected %02h last %0b, got %02h last %0b",
                       want.out_byte, want.packet_last, out_tdata, out_tlast);
          end
        end
        out_gap = draw_gap(out_calm);
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL rtp_h264_nal_packetizer");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      RegPayloadType:   pt_reg = value[6:0];
      RegSourceId:      ssrc_reg = value;
      RegMaxPayload:    max_payload_reg = value[10:0];
      RegTimestampStep: ts_step_reg = value[16:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (nal_bytes_to_send.size() > 0 || in_tvalid || rtp_bytes_due.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_registers(input logic [6:0] pt, input logic [31:0] ssrc,
                               input logic [10:0] mp, input logic [16:0] step);
    wait_idle();
    reg_write(RegPayloadType, {25'd0, pt});
    reg_write(RegSourceId, ssrc);
    reg_write(RegMaxPayload, {21'd0, mp});
    reg_write(RegTimestampStep, {15'd0, step});
  endtask

  // queues count bytes of a unit that announces the given length
  function automatic int unsigned queue_unit(input logic [20:0] announced,
                                             input int unsigned count);
    nal_item_t it;
    bit        odd_prefix;
    odd_prefix = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < count; i++) begin
      if (odd_prefix || i > 3) it.data_byte = 8'($urandom_range(0, 255));
      else it.data_byte = (i == 3) ? 8'h01 : 8'h00;
      it.first_byte = (i == 0);
      it.nal_length = (i == 0) ? announced : 21'($urandom);
      nal_bytes_to_send.push_back(it);
    end
    return count;
  endfunction

  function automatic int unsigned queue_stray();
    nal_item_t it;
    it.data_byte = 8'($urandom_range(0, 255));
    it.first_byte = 1'b0;
    it.nal_length = 21'($urandom);
    nal_bytes_to_send.push_back(it);
    return 1;
  endfunction

  initial begin
    int unsigned n;
    int unsigned kind;
    int unsigned len;
    reset_packetizer_image();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: short, minimal, stray, oversized, abandoned and overlong units
    n = queue_unit(21'd5, 5);
    n = queue_unit(21'd6, 6);
    n = queue_stray();
    n = queue_unit(21'd0, 1);
    n = queue_unit(21'h1fffff, 2);
    n = queue_unit(21'd1048576, 6);
    n = queue_unit(21'd8, 10);

    // tiny payload below the floor, all-ones header fields
    set_registers(7'd127, 32'hffffffff, 11'd1, 17'd90000);
    n = queue_unit(21'd9, 9);
    n = queue_unit(21'd7, 7);

    // payload boundary: exact fit, then one byte over
    set_registers(7'd0, 32'h0, 11'd12, 17'd0);
    n = queue_unit(21'd16, 16);
    n = queue_unit(21'd17, 17);

    for (int ph = 0; ph < 3; ph++) begin
      set_registers(7'($urandom_range(0, 127)), $urandom,
                    11'($urandom_range(0, 24)), 17'($urandom_range(0, 90000)));
      n = 0;
      while (n < 16) begin
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          len = $urandom_range(6, 24);
          n += queue_unit(21'(len), len);
        end else if (kind < 83) begin
          len = $urandom_range(6, 24);
          n += queue_unit(21'(len), $urandom_range(1, len - 1));
        end else if (kind < 90) begin
          len = $urandom_range(0, 5);
          void'(queue_unit(21'(len), len + 1));
        end else if (kind < 95) begin
          void'(queue_stray());
        end else begin
          void'(queue_unit(21'($urandom_range(1048577, 2097151)), 3));
        end
      end
    end

    wait_idle();
    if (mismatches == 0 && rtp_bytes_due.size() == 0) begin
      $display("PASS rtp_h264_nal_packetizer");
    end else begin
      $display("FAIL rtp_h264_nal_packetizer");
    end
    $finish;
  end

endmodule
